// ===== hdl/hpcc_pkg.sv =====
// ============================================================================
// hpcc_pkg - shared types, constants and helpers of the high-pass cross filter
// Sizes of the window, line store and output queue, register indexes, and the
// clamping rules that turn raw register values into the working kernel and width.
// ============================================================================
package hpcc_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;

  localparam int NCH     = 3;                        // color channels per pixel
  localparam int CH_W    = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_KERNEL);
  localparam int ROW_MAX = MAX_KERNEL - 1;
  localparam int IDX_W   = $clog2(MAX_KERNEL);
  localparam int TOP_K   = (MAX_KERNEL - 1) | 1;
  localparam int MAX_P   = TOP_K / 2;
  localparam int P_W     = $clog2(MAX_P + 1);
  localparam int K_W     = $clog2(TOP_K + 1) + 1;
  localparam int KS_W    = 3;                        // kernel_size register
  localparam int LW_W    = 11;                       // line_width register
  localparam int SUM_W   = CH_W + 2;                 // four taps per arm step
  localparam int CW_MAX  = 2 * MAX_P * (MAX_P + 1);  // largest center weight
  localparam int CW_W    = $clog2(CW_MAX + 1);
  localparam int ACC_W   = CH_W + CW_W + 2;
  localparam int OUT_DEPTH = 8;                      // power of two
  localparam int PTR_W   = $clog2(OUT_DEPTH);
  localparam int CNT_W   = $clog2(OUT_DEPTH + 1);

  // APB
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int RIDX_W = ADDR_W - 2;
  localparam logic [RIDX_W-1:0] REG_KERNEL_SIZE = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] REG_LINE_WIDTH  = RIDX_W'(1);
  localparam logic [RIDX_W-1:0] REG_COLOR_MODE  = RIDX_W'(2);

  localparam logic [KS_W-1:0] KS_RESET = KS_W'(3);
  localparam logic [LW_W-1:0] LW_RESET = LW_W'(1024);

  typedef logic [CH_W-1:0]             pix_t;
  typedef pix_t [NCH-1:0]              px3_t;
  typedef px3_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] win_t;    // [row][col]
  typedef pix_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] chwin_t;
  typedef px3_t [MAX_KERNEL-2:0]       lrow_t;             // one column of rows

  typedef struct packed {
    logic [K_W-1:0]  k;
    logic [P_W-1:0]  p;
    logic [LW_W-1:0] width;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic last;
  } wstat_t;

  typedef struct packed {
    pix_t c0;
    pix_t c1;
    pix_t c2;
    logic last;
  } out_t;

  function automatic logic [K_W-1:0] eff_k(input logic [KS_W-1:0] ks);
    logic [K_W-1:0] k;
    k = K_W'(ks);
    if (k < K_W'(3)) k = K_W'(3);
    if (!k[0]) k = k - K_W'(1);
    if (k > K_W'(TOP_K)) k = K_W'(TOP_K);
    return k;
  endfunction

  function automatic logic [LW_W-1:0] eff_w(input logic [LW_W-1:0] lw);
    logic [LW_W-1:0] w;
    w = lw;
    if (w < LW_W'(3)) w = LW_W'(3);
    if (32'(w) > MAX_WIDTH) w = LW_W'(MAX_WIDTH);
    return w;
  endfunction

endpackage

// ===== hdl/hpcc_if.sv =====
// ============================================================================
// hpcc_if - stream channels of the high-pass cross filter
// Pixel request channel and filtered result channel, valid/ready handshake.
// ============================================================================
interface hpcc_in_if;
  logic              valid;
  logic              ready;
  hpcc_pkg::pix_t    chan0_in;
  hpcc_pkg::pix_t    chan1_in;
  hpcc_pkg::pix_t    chan2_in;
  logic              frame_start;

  modport source (output valid, chan0_in, chan1_in, chan2_in, frame_start, input ready);
  modport sink   (input valid, chan0_in, chan1_in, chan2_in, frame_start, output ready);
endinterface

interface hpcc_out_if;
  logic              valid;
  logic              ready;
  hpcc_pkg::pix_t    chan0_out;
  hpcc_pkg::pix_t    chan1_out;
  hpcc_pkg::pix_t    chan2_out;
  logic              row_last;

  modport source (output valid, chan0_out, chan1_out, chan2_out, row_last, input ready);
  modport sink   (input valid, chan0_out, chan1_out, chan2_out, row_last, output ready);
endinterface

// ===== hdl/hpcc_window.sv =====
// ============================================================================
// hpcc_window - line store, raster counters and the square pixel window
// Reads a column of past rows on accept, shifts the window and rewrites the
// column in the next cycle, forwarding when two requests hit the same column.
// ============================================================================
module hpcc_window (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  hpcc_pkg::px3_t   pixel_i,
  input  logic             frame_start_i,
  input  hpcc_pkg::cfg_t   cfg_i,
  output logic             emit_o,
  output hpcc_pkg::win_t   win_o,
  output hpcc_pkg::wstat_t stat_o
);

  logic [hpcc_pkg::COL_W-1:0] col_q, col_cur;
  logic [hpcc_pkg::ROW_W-1:0] row_q, row_cur;
  logic                       last;

  hpcc_pkg::lrow_t mem [hpcc_pkg::MAX_WIDTH];
  hpcc_pkg::lrow_t rd_q, fwd_row_q, ls_rd, wr_row;
  logic            fwd_q;

  logic                       s1_vld_q;
  logic [hpcc_pkg::COL_W-1:0] s1_col_q;
  hpcc_pkg::px3_t             s1_px_q;
  logic                       s1_emit_q, s1_last_q;

  hpcc_pkg::win_t   win_q;
  hpcc_pkg::wstat_t stat_q;

  // frame start clears the counters before the marked pixel
  assign col_cur = frame_start_i ? '0 : col_q;
  assign row_cur = frame_start_i ? '0 : row_q;
  assign last    = 32'(col_cur) >= 32'(cfg_i.width) - 32'd1;
  assign emit_o  = (32'(row_cur) >= 32'(cfg_i.k) - 32'd1) &&
                   (32'(col_cur) >= 32'(cfg_i.k) - 32'd1);

  assign ls_rd = fwd_q ? fwd_row_q : rd_q;

  always_comb begin
    wr_row[0] = s1_px_q;
    for (int i = 1; i < hpcc_pkg::MAX_KERNEL - 1; i++) begin
      wr_row[i] = ls_rd[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q      <= mem[col_cur];
      fwd_q     <= s1_vld_q && (col_cur == s1_col_q);
      fwd_row_q <= wr_row;
      s1_col_q  <= col_cur;
      s1_px_q   <= pixel_i;
      s1_emit_q <= emit_o;
      s1_last_q <= last;
    end
    if (s1_vld_q) begin
      mem[s1_col_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
      win_q    <= '0;
      stat_q   <= '0;
    end else begin
      s1_vld_q    <= accept_i;
      stat_q.vld  <= s1_vld_q && s1_emit_q;
      stat_q.last <= s1_last_q;
      if (accept_i) begin
        if (last) begin
          col_q <= '0;
          row_q <= (row_cur < hpcc_pkg::ROW_W'(hpcc_pkg::ROW_MAX)) ?
                   row_cur + hpcc_pkg::ROW_W'(1) : row_cur;
        end else begin
          col_q <= col_cur + hpcc_pkg::COL_W'(1);
          row_q <= row_cur;
        end
      end
      if (s1_vld_q) begin
        for (int i = 0; i < hpcc_pkg::MAX_KERNEL; i++) begin
          for (int j = hpcc_pkg::MAX_KERNEL - 1; j > 0; j--) begin
            win_q[i][j] <= win_q[i][j-1];
          end
        end
        win_q[0][0] <= s1_px_q;
        for (int i = 1; i < hpcc_pkg::MAX_KERNEL; i++) begin
          win_q[i][0] <= ls_rd[i-1];
        end
      end
    end
  end

  assign win_o  = win_q;
  assign stat_o = stat_q;

endmodule

// ===== hdl/hpcc_lane.sv =====
// ============================================================================
// hpcc_lane - cross high-pass filter for one channel
// Stage one adds the four taps at each arm distance, stage two applies the
// weights, subtracts from the weighted center and clamps to 0..255.
// ============================================================================
module hpcc_lane (
  input  logic                       clk_i,
  input  hpcc_pkg::chwin_t           win_i,
  input  logic [hpcc_pkg::P_W-1:0]   p_i,
  output hpcc_pkg::pix_t             res_o
);

  logic [hpcc_pkg::MAX_P-1:0][hpcc_pkg::SUM_W-1:0] sum_d, sum_q;
  hpcc_pkg::pix_t ctr_d, ctr_q, res_q;
  hpcc_pkg::pix_t res_d;

  always_comb begin
    logic [hpcc_pkg::IDX_W-1:0] c, up, dn;
    c     = hpcc_pkg::IDX_W'(p_i);
    ctr_d = win_i[c][c];
    for (int d = 1; d <= hpcc_pkg::MAX_P; d++) begin
      up         = hpcc_pkg::IDX_W'(32'(p_i) + 32'(d));
      dn         = hpcc_pkg::IDX_W'(32'(p_i) - 32'(d));
      sum_d[d-1] = '0;
      if (32'(d) <= 32'(p_i)) begin
        sum_d[d-1] = hpcc_pkg::SUM_W'(win_i[up][c]) + hpcc_pkg::SUM_W'(win_i[dn][c]) +
                     hpcc_pkg::SUM_W'(win_i[c][up]) + hpcc_pkg::SUM_W'(win_i[c][dn]);
      end
    end
  end

  always_comb begin
    logic [hpcc_pkg::CW_W-1:0]  cw;
    logic [hpcc_pkg::ACC_W-1:0] pos, neg, diff;
    cw  = hpcc_pkg::CW_W'(32'd2 * 32'(p_i) * (32'(p_i) + 32'd1));
    pos = hpcc_pkg::ACC_W'(ctr_q) * hpcc_pkg::ACC_W'(cw);
    neg = '0;
    for (int d = 1; d <= hpcc_pkg::MAX_P; d++) begin
      if (32'(d) <= 32'(p_i)) begin
        neg = neg + hpcc_pkg::ACC_W'(sum_q[d-1]) *
                    hpcc_pkg::ACC_W'(32'(p_i) - 32'(d) + 32'd1);
      end
    end
    diff = pos - neg;
    if (neg > pos) begin
      res_d = '0;
    end else if (diff > hpcc_pkg::ACC_W'(255)) begin
      res_d = hpcc_pkg::pix_t'(255);
    end else begin
      res_d = diff[hpcc_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ctr_q <= ctr_d;
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== hdl/hpcc_merge.sv =====
// ============================================================================
// hpcc_merge - joins the lane results into result items and queues them
// Aligns row_last with the lanes, zeros the color lanes in gray mode, and
// grants pixel requests only while the queue has room for all in flight.
// ============================================================================
module hpcc_merge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   issue_i,
  input  hpcc_pkg::wstat_t                       stat_i,
  input  hpcc_pkg::pix_t [hpcc_pkg::NCH-1:0]     res_i,
  input  logic                                   color_i,
  output logic                                   ready_o,
  hpcc_out_if.source                             res_o
);

  logic [1:0] vld_q, last_q;
  logic       push, pop;

  hpcc_pkg::out_t             fifo_q [hpcc_pkg::OUT_DEPTH];
  hpcc_pkg::out_t             entry;
  logic [hpcc_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [hpcc_pkg::CNT_W-1:0] cnt_q, cnt_d, pend_q, pend_d;

  assign push = vld_q[1];
  assign pop  = res_o.valid && res_o.ready;

  always_comb begin
    entry.c0   = res_i[0];
    entry.c1   = color_i ? res_i[1] : '0;
    entry.c2   = color_i ? res_i[2] : '0;
    entry.last = last_q[1];
  end

  // room for every queued result and every one still in the pipeline
  assign ready_o = (hpcc_pkg::CNT_W+1)'(cnt_q) + (hpcc_pkg::CNT_W+1)'(pend_q)
                   < (hpcc_pkg::CNT_W+1)'(hpcc_pkg::OUT_DEPTH);

  assign cnt_d  = cnt_q + hpcc_pkg::CNT_W'(push) - hpcc_pkg::CNT_W'(pop);
  assign pend_d = pend_q + hpcc_pkg::CNT_W'(issue_i) - hpcc_pkg::CNT_W'(push);

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[0], stat_i.last};
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      pend_q   <= '0;
    end else begin
      vld_q  <= {vld_q[0], stat_i.vld};
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      if (push) wr_ptr_q <= wr_ptr_q + hpcc_pkg::PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + hpcc_pkg::PTR_W'(1);
    end
  end

  assign res_o.valid     = cnt_q != '0;
  assign res_o.chan0_out = fifo_q[rd_ptr_q].c0;
  assign res_o.chan1_out = fifo_q[rd_ptr_q].c1;
  assign res_o.chan2_out = fifo_q[rd_ptr_q].c2;
  assign res_o.row_last  = fifo_q[rd_ptr_q].last;

endmodule

// ===== hdl/high_pass_cross_convolution.sv =====
// ============================================================================
// high_pass_cross_convolution - streaming cross-shaped high-pass filter
// Raster pixels in, clamped sharpened center pixels out, one lane per channel.
// ============================================================================
//
//   channel   dir  handshake       payload
//   pix_i     in   valid/ready     chan0_in, chan1_in, chan2_in, frame_start
//   res_o     out  valid/ready     chan0_out, chan1_out, chan2_out, row_last
//   apb       in   psel/penable    paddr, pwdata, prdata (pready tied high)
//
// One pixel request per clock while the queue has room. A result enters the
// 8-entry output queue after the line store read, the window register and
// the two lane stages.
// Reset clears counters, window and queue; the line store is not cleared,
// its entries are written before any read in a well-formed frame.
// A stalled result side fills the queue, then pix_i.ready drops.
//
// Registers (byte address 4*i): kernel_size, line_width, color_mode.
module high_pass_cross_convolution (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpcc_pkg::ADDR_W-1:0]   paddr,
  input  logic [hpcc_pkg::DATA_W-1:0]   pwdata,
  output logic [hpcc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  hpcc_in_if.sink                       pix_i,
  hpcc_out_if.source                    res_o
);

  // configuration registers
  logic [hpcc_pkg::KS_W-1:0]   kernel_size_q;
  logic [hpcc_pkg::LW_W-1:0]   line_width_q;
  logic                        color_mode_q;
  logic                        cfg_we;
  logic [hpcc_pkg::RIDX_W-1:0] reg_idx;

  hpcc_pkg::cfg_t              cfg;
  logic                        accept, emit, ready;
  hpcc_pkg::px3_t              pixel;
  hpcc_pkg::win_t              win;
  hpcc_pkg::wstat_t            stat;
  hpcc_pkg::chwin_t            chwin [hpcc_pkg::NCH];
  hpcc_pkg::pix_t [hpcc_pkg::NCH-1:0] lane_res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hpcc_pkg::ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q <= hpcc_pkg::KS_RESET;
      line_width_q  <= hpcc_pkg::LW_RESET;
      color_mode_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        hpcc_pkg::REG_KERNEL_SIZE: kernel_size_q <= pwdata[hpcc_pkg::KS_W-1:0];
        hpcc_pkg::REG_LINE_WIDTH:  line_width_q  <= pwdata[hpcc_pkg::LW_W-1:0];
        hpcc_pkg::REG_COLOR_MODE:  color_mode_q  <= pwdata[0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hpcc_pkg::REG_KERNEL_SIZE: prdata = hpcc_pkg::DATA_W'(kernel_size_q);
      hpcc_pkg::REG_LINE_WIDTH:  prdata = hpcc_pkg::DATA_W'(line_width_q);
      hpcc_pkg::REG_COLOR_MODE:  prdata = hpcc_pkg::DATA_W'(color_mode_q);
      default:                   prdata = '0;
    endcase
  end

  // working kernel side, half-width and line width after clamping
  always_comb begin
    cfg.k     = hpcc_pkg::eff_k(kernel_size_q);
    cfg.p     = hpcc_pkg::P_W'(cfg.k >> 1);
    cfg.width = hpcc_pkg::eff_w(line_width_q);
  end

  assign pix_i.ready = ready;
  assign accept      = pix_i.valid && ready;
  assign pixel       = {pix_i.chan2_in, pix_i.chan1_in, pix_i.chan0_in};

  hpcc_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_i       (pixel),
    .frame_start_i (pix_i.frame_start),
    .cfg_i         (cfg),
    .emit_o        (emit),
    .win_o         (win),
    .stat_o        (stat)
  );

  // split the window into one plane per channel
  always_comb begin
    for (int c = 0; c < hpcc_pkg::NCH; c++) begin
      for (int i = 0; i < hpcc_pkg::MAX_KERNEL; i++) begin
        for (int j = 0; j < hpcc_pkg::MAX_KERNEL; j++) begin
          chwin[c][i][j] = win[i][j][c];
        end
      end
    end
  end

  for (genvar c = 0; c < hpcc_pkg::NCH; c++) begin : g_lane
    hpcc_lane u_lane (
      .clk_i (clk_i),
      .win_i (chwin[c]),
      .p_i   (cfg.p),
      .res_o (lane_res[c])
    );
  end

  hpcc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (accept && emit),
    .stat_i  (stat),
    .res_i   (lane_res),
    .color_i (color_mode_q),
    .ready_o (ready),
    .res_o   (res_o)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - self-checking bench of the high-pass cross convolution
// Streams padded raster frames through the pixel channel, predicts every
// filtered center pixel with a behavioral copy of the filter, and compares
// each result request field by field. Covers all kernel sizes, width clamps,
// gray and color mode, frame restarts, a mid-row width shrink, and a long
// result-side stall that backs up the pixel input.
// ============================================================================
module testbench;

  localparam int CLK_HALF       = 6;
  localparam int GAP_MAX        = 18;    // longest random idle per request
  localparam int DRAIN_CYCLES   = 12;
  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 750;
  localparam int TOP_SIDE       = (hpcc_pkg::MAX_KERNEL - 1) | 1;
  localparam logic [hpcc_pkg::RIDX_W-1:0] REG_SPARE = hpcc_pkg::RIDX_W'(3);  // unmapped

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [hpcc_pkg::ADDR_W-1:0] paddr;
  logic [hpcc_pkg::DATA_W-1:0] pwdata;
  logic [hpcc_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  hpcc_in_if  pix_if ();
  hpcc_out_if res_if ();

  high_pass_cross_convolution i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_if),
    .res_o   (res_if)
  );

  // --------------------------------------------------------------------------
  // Filter predictor state: shadow registers, line history, window, counters
  // --------------------------------------------------------------------------
  logic [hpcc_pkg::KS_W-1:0] ks_reg;
  logic [hpcc_pkg::LW_W-1:0] lw_reg;
  logic                      cm_reg;
  // [rows above][column]
  logic [23:0] hist_rows [hpcc_pkg::MAX_KERNEL-1][hpcc_pkg::MAX_WIDTH];
  // [row up][column left]
  logic [23:0] win_px    [hpcc_pkg::MAX_KERNEL][hpcc_pkg::MAX_KERNEL];
  int          col_pos;
  int          row_pos;

  hpcc_pkg::out_t expected_px [$];   // filtered pixels still owed by the block
  hpcc_pkg::out_t want;
  int             err_cnt = 0;
  int             quiet_cycles = 0;

  // Idle controls shared by the stimulus and the result sink
  bit tx_gaps;
  bit rx_gaps;
  int hold_seq = 0;    // bumped by a test to ask for a long hold
  int hold_seen = 0;
  int rx_wait = 0;
  int rx_hold = 0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Working kernel side: below 3 acts as 3, even sizes drop to the odd below
  function automatic int eff_side();
    int k;
    k = int'(ks_reg);
    if (k < 3) k = 3;
    if (k % 2 == 0) k = k - 1;
    if (k > TOP_SIDE) k = TOP_SIDE;
    return k;
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(lw_reg);
    if (w < 3) w = 3;
    if (w > hpcc_pkg::MAX_WIDTH) w = hpcc_pkg::MAX_WIDTH;
    return w;
  endfunction

  // Cross kernel on one channel: arm tap at distance d weighs -(p-d+1),
  // the center carries the negated arm total, result clamped to a byte.
  function automatic hpcc_pkg::pix_t cross_filter(input int p, input int ch);
    int acc;
    int center_wt;
    int arm;
    int taps;
    acc       = 0;
    center_wt = 0;
    for (int d = 1; d <= p; d++) begin
      arm  = p - d + 1;
      taps = int'(win_px[p+d][p][8*ch +: 8]) + int'(win_px[p-d][p][8*ch +: 8])
           + int'(win_px[p][p+d][8*ch +: 8]) + int'(win_px[p][p-d][8*ch +: 8]);
      acc       = acc - arm * taps;
      center_wt = center_wt + 4 * arm;
    end
    acc = acc + center_wt * int'(win_px[p][p][8*ch +: 8]);
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return hpcc_pkg::pix_t'(acc);
  endfunction

  // Advances the predictor by one accepted pixel; returns 1 when a result is due
  function automatic bit sharpen_step(input logic [23:0] px, input logic fs,
                                      output hpcc_pkg::out_t res);
    int  k;
    int  p;
    int  w;
    int  c;
    bit  last;
    bit  hit;
    k = eff_side();
    p = k / 2;
    w = eff_width();
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c    = (col_pos >= hpcc_pkg::MAX_WIDTH) ? hpcc_pkg::MAX_WIDTH - 1 : col_pos;
    // a width that shrank under the column count ends the row here
    last = col_pos >= w - 1;
    for (int i = 0; i < hpcc_pkg::MAX_KERNEL; i++)
      for (int j = hpcc_pkg::MAX_KERNEL - 1; j > 0; j--)
        win_px[i][j] = win_px[i][j-1];
    win_px[0][0] = px;
    for (int i = 1; i < hpcc_pkg::MAX_KERNEL; i++)
      win_px[i][0] = hist_rows[i-1][c];
    for (int i = hpcc_pkg::MAX_KERNEL - 2; i > 0; i--)
      hist_rows[i][c] = hist_rows[i-1][c];
    hist_rows[0][c] = px;
    hit = row_pos >= k - 1 && col_pos >= k - 1;
    if (last) begin
      col_pos = 0;
      if (row_pos < hpcc_pkg::MAX_KERNEL - 1) row_pos++;
    end else begin
      col_pos = (col_pos + 1) & 32'h3FF;
    end
    res.c0   = cross_filter(p, 0);
    res.c1   = cm_reg ? cross_filter(p, 1) : '0;
    res.c2   = cm_reg ? cross_filter(p, 2) : '0;
    res.last = last;
    return hit;
  endfunction

  function automatic hpcc_pkg::pix_t rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return hpcc_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Register write: setup cycle, access cycle, then an idle gap so that
  // back-to-back writes never assign psel twice in one step.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [hpcc_pkg::RIDX_W-1:0] idx,
                           input logic [hpcc_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      hpcc_pkg::REG_KERNEL_SIZE: ks_reg = val[hpcc_pkg::KS_W-1:0];
      hpcc_pkg::REG_LINE_WIDTH:  lw_reg = val[hpcc_pkg::LW_W-1:0];
      hpcc_pkg::REG_COLOR_MODE:  cm_reg = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Pixel request: optional random idle, then hold valid until accepted.
  // The predictor runs at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input hpcc_pkg::pix_t c0, input hpcc_pkg::pix_t c1,
                            input hpcc_pkg::pix_t c2, input logic fs);
    int             gap;
    hpcc_pkg::out_t res;
    gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.chan0_in    <= c0;
    pix_if.chan1_in    <= c1;
    pix_if.chan2_in    <= c2;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (!pix_if.ready);
    if (sharpen_step({c2, c1, c0}, fs, res)) expected_px.push_back(res);
  endtask

  // Drop valid, wait for every owed result, then let pixels that produce
  // nothing clear the pipeline before touching registers.
  task automatic settle_pipeline();
    pix_if.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Directed: 3x3 kernel, width 5, checkerboard so every center sits among
  // opposite values and both clamps show; chan1 is inverted, chan2 a ramp.
  // Then a gray row and a masked kernel write.
  // --------------------------------------------------------------------------
  task automatic test_directed();
    hpcc_pkg::pix_t v;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    cfg_write(hpcc_pkg::REG_KERNEL_SIZE, 32'd3);
    cfg_write(hpcc_pkg::REG_LINE_WIDTH, 32'd5);
    cfg_write(hpcc_pkg::REG_COLOR_MODE, 32'd1);
    cfg_write(REG_SPARE, '1);          // unmapped, must change nothing
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 5; c++) begin
        v = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
        send_pixel(v, ~v, hpcc_pkg::pix_t'(40 * c + r), r == 0 && c == 0);
      end
    end
    settle_pipeline();
    cfg_write(hpcc_pkg::REG_COLOR_MODE, 32'd0);
    cfg_write(hpcc_pkg::REG_KERNEL_SIZE, 32'hFFFF_FFF8);  // low bits zero -> 3x3
    // side channels all ones: gray mode must still report zero there
    for (int c = 0; c < 5; c++) begin
      v = ((3 + c) % 2 != 0) ? 8'hFF : 8'h00;
      send_pixel(v, 8'hFF, 8'hFF, 1'b0);
    end
    settle_pipeline();
  endtask

  // --------------------------------------------------------------------------
  // Backpressure: result side holds off for a long stretch while pixels
  // stream without gaps, so the output queue fills and pix ready drops.
  // --------------------------------------------------------------------------
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    cfg_write(hpcc_pkg::REG_KERNEL_SIZE, 32'd5);
    cfg_write(hpcc_pkg::REG_LINE_WIDTH, 32'd12);
    cfg_write(hpcc_pkg::REG_COLOR_MODE, 32'd1);
    hold_seq++;
    for (int i = 0; i < 120; i++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    settle_pipeline();
  endtask

  // --------------------------------------------------------------------------
  // Widest line: an oversized width that clamps to 1024 for a full row and
  // part of the next, then a shrink to 8 while the column count sits at 16
  // so the next pixel ends the row.
  // --------------------------------------------------------------------------
  task automatic test_wide_line();
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    cfg_write(hpcc_pkg::REG_KERNEL_SIZE, 32'd3);
    cfg_write(hpcc_pkg::REG_COLOR_MODE, 32'd0);
    cfg_write(hpcc_pkg::REG_LINE_WIDTH, 32'd2047);
    for (int i = 0; i < hpcc_pkg::MAX_WIDTH + 16; i++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
    settle_pipeline();
    cfg_write(hpcc_pkg::REG_LINE_WIDTH, 32'd8);
    for (int i = 0; i < 24; i++)
      send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
    settle_pipeline();
  endtask

  // --------------------------------------------------------------------------
  // Random phases: random kernel (all eight codes), small widths with the
  // odd one below 3 or below the kernel, random mode. Mostly whole frames,
  // some cut short, rare stray frame starts mid-row.
  // --------------------------------------------------------------------------
  task automatic test_random_frames(input int budget);
    int   sent;
    int   lw;
    int   k_eff;
    int   w_eff;
    int   rows;
    int   cut;
    logic fs;
    sent = 0;
    while (sent < budget) begin
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      cfg_write(hpcc_pkg::REG_KERNEL_SIZE, $urandom());
      case ($urandom_range(0, 9))
        0:       lw = $urandom_range(0, 2);
        1:       lw = $urandom_range(3, 6);
        default: lw = $urandom_range(5, 14);
      endcase
      cfg_write(hpcc_pkg::REG_LINE_WIDTH, ($urandom() & ~32'h7FF) | 32'(lw));
      cfg_write(hpcc_pkg::REG_COLOR_MODE, $urandom());
      if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom());
      k_eff = eff_side();
      w_eff = eff_width();
      repeat ($urandom_range(1, 3)) begin
        rows = $urandom_range(k_eff, k_eff + 4);
        cut  = rows * w_eff;
        if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, cut);
        for (int i = 0; i < cut; i++) begin
          fs = (i == 0) || ($urandom_range(0, 199) == 0);
          send_pixel(rand_chan(), rand_chan(), rand_chan(), fs);
          sent++;
        end
      end
      settle_pipeline();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink and checker. Each accepted result request is compared with
  // the oldest owed pixel; afterwards ready idles for a random count when
  // rx_gaps is set, or for a long hold when a test asks for one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_px.size() == 0) begin
        $error("result request with no pixel pending");
        err_cnt++;
      end else begin
        want = expected_px.pop_front();
        if (res_if.chan0_out !== want.c0) begin
          $error("chan0_out: expected %0d, got %0d", want.c0, res_if.chan0_out);
          err_cnt++;
        end
        if (res_if.chan1_out !== want.c1) begin
          $error("chan1_out: expected %0d, got %0d", want.c1, res_if.chan1_out);
          err_cnt++;
        end
        if (res_if.chan2_out !== want.c2) begin
          $error("chan2_out: expected %0d, got %0d", want.c2, res_if.chan2_out);
          err_cnt++;
        end
        if (res_if.row_last !== want.last) begin
          $error("row_last: expected %0d, got %0d", want.last, res_if.row_last);
          err_cnt++;
        end
      end
      rx_wait = rx_gaps ? $urandom_range(0, GAP_MAX) : 0;
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      rx_hold   = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      res_if.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_if.valid       = 1'b0;
    pix_if.chan0_in    = '0;
    pix_if.chan1_in    = '0;
    pix_if.chan2_in    = '0;
    pix_if.frame_start = 1'b0;
    tx_gaps            = 1'b0;
    rx_gaps            = 1'b0;
    // predictor mirrors the reset state
    ks_reg  = hpcc_pkg::KS_RESET;
    lw_reg  = hpcc_pkg::LW_RESET;
    cm_reg  = 1'b0;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < hpcc_pkg::MAX_KERNEL; i++)
      for (int j = 0; j < hpcc_pkg::MAX_KERNEL; j++)
        win_px[i][j] = '0;
    for (int i = 0; i < hpcc_pkg::MAX_KERNEL - 1; i++)
      for (int j = 0; j < hpcc_pkg::MAX_WIDTH; j++)
        hist_rows[i][j] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_wide_line();
    test_random_frames(RANDOM_ITEMS);

    settle_pipeline();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/hpcc_pkg.sv
hdl/hpcc_if.sv
hdl/hpcc_window.sv
hdl/hpcc_lane.sv
hdl/hpcc_merge.sv
hdl/high_pass_cross_convolution.sv
sim/testbench.sv
